FILE: src/tmtw_pkg.sv
// Shared types, constants and helpers for the text-mode terminal writer.
// No dependencies; used by every other file of the block.
`default_nettype none

package tmtw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int CLR_W  = 4;
    localparam int CELL_W = 16;
    localparam int CFG_W  = CLR_W;

    // command modes
    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // configuration register indexes
    localparam logic CFG_FG = 1'b0;
    localparam logic CFG_BG = 1'b1;

    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CLR_W-1:0]  RESET_FG   = 4'hF;
    localparam logic [CLR_W-1:0]  RESET_BG   = 4'h0;

    typedef struct packed {
        logic [1:0]        mode;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  cell_row;
        logic [COL_W-1:0]  cell_col;
    } cmd_t;

    typedef struct packed {
        logic [CHAR_W-1:0] read_char;
        logic [CLR_W-1:0]  read_fg;
        logic [CLR_W-1:0]  read_bg;
        logic [ROW_W-1:0]  now_row;
        logic [COL_W-1:0]  now_col;
        logic              did_scroll;
    } result_t;

    function automatic logic [CELL_W-1:0] make_cell(
        input logic [CLR_W-1:0]  bg,
        input logic [CLR_W-1:0]  fg,
        input logic [CHAR_W-1:0] ch
    );
        return {bg, fg, ch};
    endfunction

    localparam logic [CELL_W-1:0] RESET_CELL = {RESET_BG, RESET_FG, CH_SPACE};

endpackage

`default_nettype wire

FILE: src/tmtw_screen_ram.sv
// Screen cell store: one write port, one read port, registered read data.
// Depends on tmtw_pkg for the cell width and the default depth.
`default_nettype none

module tmtw_screen_ram #(
    parameter int DEPTH = tmtw_pkg::COLUMNS_DEF * tmtw_pkg::ROWS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [AW-1:0]               waddr,
    input  wire logic [tmtw_pkg::CELL_W-1:0] wdata,
    input  wire logic [AW-1:0]               raddr,
    output logic      [tmtw_pkg::CELL_W-1:0] rdata
);

    logic [tmtw_pkg::CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/text_mode_terminal_writer_core.sv
// Top level of the text-mode terminal writer: command decode, cursor and screen walks.
// Depends on tmtw_pkg and tmtw_screen_ram.
`default_nettype none

// A command is taken when start is high and busy is low; its result appears on
// result for exactly one cycle with done high and must be captured then, as the
// receiver cannot hold it off. A put that does not scroll (newline included)
// answers straight from idle with a registered result. A read of a cell passes
// through S_READ for the registered memory read; a read out of range or an
// unused mode answers straight from idle. Clear and a put that scrolls walk
// every cell through the single write port of the screen memory, one cell a
// cycle, then pass through S_FLUSH before the result. After reset the block is
// busy while it blanks the screen; no result is produced for that pass. Colour
// registers are to be written only while the block is idle, so that they apply
// to a whole command; the block itself does not enforce this.
module text_mode_terminal_writer_core #(
    parameter int COLUMNS = tmtw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tmtw_pkg::ROWS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire tmtw_pkg::cmd_t             cmd,
    output logic                            done,
    output tmtw_pkg::result_t               result,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [tmtw_pkg::CFG_W-1:0] cfg_data
);

    localparam int CELLS      = ROWS * COLUMNS;
    localparam int AW         = $clog2(CELLS);
    localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;
    localparam int ROW_W      = tmtw_pkg::ROW_W;
    localparam int COL_W      = tmtw_pkg::COL_W;
    localparam int CLR_W      = tmtw_pkg::CLR_W;
    localparam int CELL_W     = tmtw_pkg::CELL_W;

    localparam logic [AW-1:0]    LAST_ADDR  = AW'(CELLS - 1);
    localparam logic [AW-1:0]    COPY_END   = AW'(COPY_CELLS);
    localparam logic [AW-1:0]    ROW_STRIDE = AW'(COLUMNS);
    localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(ROWS - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_WALK  = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        W_INIT   = 2'd0,
        W_CLEAR  = 2'd1,
        W_SCROLL = 2'd2
    } walk_t;

    state_t             state_reg, state_next;
    walk_t              kind_reg, kind_next;
    logic [AW-1:0]      cnt_reg, cnt_next;
    logic               wr_pend_reg, wr_pend_next;
    logic               wr_blank_reg, wr_blank_next;
    logic [AW-1:0]      wr_addr_reg, wr_addr_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [CLR_W-1:0]   fg_reg, bg_reg;
    logic               done_reg, done_next;
    tmtw_pkg::result_t  result_reg, result_next;

    logic               accept;
    logic               is_nl;
    logic [COL_W:0]     col_adv;
    logic               wrap;
    logic [COL_W-1:0]   col_put;
    logic [ROW_W:0]     row_put;
    logic               need_scroll;
    logic               req_in_range;
    logic [AW-1:0]      req_addr;
    logic [AW-1:0]      cur_addr;
    logic               walk_copy;
    logic               put_wr;
    logic [CELL_W-1:0]  blank_cell;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [CELL_W-1:0]  mem_rdata;

    assign accept = start && (state_reg == S_IDLE);

    // cursor arithmetic for a put
    assign is_nl       = (cmd.char_code == tmtw_pkg::CH_NEWLINE);
    assign col_adv     = is_nl ? '0 : ({1'b0, col_reg} + (COL_W+1)'(1));
    assign wrap        = (int'(col_adv) >= COLUMNS);
    assign col_put     = wrap ? '0 : col_adv[COL_W-1:0];
    assign row_put     = {1'b0, row_reg} + (ROW_W+1)'(is_nl || wrap);
    assign need_scroll = (int'(row_put) >= ROWS);

    assign cur_addr     = AW'(int'(row_reg) * COLUMNS + int'(col_reg));
    assign req_in_range = (int'(cmd.cell_row) < ROWS) && (int'(cmd.cell_col) < COLUMNS);
    assign req_addr     = AW'(int'(cmd.cell_row) * COLUMNS + int'(cmd.cell_col));

    assign walk_copy  = (kind_reg == W_SCROLL) && (cnt_reg < COPY_END);
    assign blank_cell = (kind_reg == W_INIT) ? tmtw_pkg::RESET_CELL :
                        tmtw_pkg::make_cell(bg_reg, fg_reg, tmtw_pkg::CH_SPACE);

    assign put_wr = accept && (cmd.mode == tmtw_pkg::MODE_PUT) && !is_nl;

    // a pending walk write and a put never meet: puts are only taken when idle
    assign mem_we    = wr_pend_reg || put_wr;
    assign mem_waddr = wr_pend_reg ? wr_addr_reg : cur_addr;
    assign mem_wdata = wr_pend_reg ? (wr_blank_reg ? blank_cell : mem_rdata) :
                       tmtw_pkg::make_cell(bg_reg, fg_reg, cmd.char_code);

    always_comb
    begin
        if (state_reg == S_WALK)
        begin
            mem_raddr = walk_copy ? (cnt_reg + ROW_STRIDE) : '0;
        end
        else
        begin
            mem_raddr = req_in_range ? req_addr : '0;
        end
    end

    tmtw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        cnt_next      = cnt_reg;
        wr_pend_next  = wr_pend_reg;
        wr_blank_next = wr_blank_reg;
        wr_addr_next  = wr_addr_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        done_next     = 1'b0;
        result_next   = result_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    result_next            = '0;
                    result_next.now_row    = row_reg;
                    result_next.now_col    = col_reg;
                    case (cmd.mode)
                        tmtw_pkg::MODE_PUT:
                        begin
                            if (need_scroll)
                            begin
                                row_next   = LAST_ROW;
                                col_next   = '0;
                                kind_next  = W_SCROLL;
                                cnt_next   = '0;
                                state_next = S_WALK;
                            end
                            else
                            begin
                                row_next            = row_put[ROW_W-1:0];
                                col_next            = col_put;
                                result_next.now_row = row_put[ROW_W-1:0];
                                result_next.now_col = col_put;
                                done_next           = 1'b1;
                            end
                        end
                        tmtw_pkg::MODE_CLEAR:
                        begin
                            kind_next  = W_CLEAR;
                            cnt_next   = '0;
                            state_next = S_WALK;
                        end
                        tmtw_pkg::MODE_READ:
                        begin
                            if (req_in_range)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                result_next.read_char = mem_rdata[7:0];
                result_next.read_fg   = mem_rdata[11:8];
                result_next.read_bg   = mem_rdata[15:12];
                done_next             = 1'b1;
                state_next            = S_IDLE;
            end
            S_WALK:
            begin
                // read issued now, its write lands in the next cycle
                wr_pend_next  = 1'b1;
                wr_addr_next  = cnt_reg;
                wr_blank_next = !walk_copy;
                cnt_next      = cnt_reg + AW'(1);
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                wr_pend_next = 1'b0;
                state_next   = S_IDLE;
                if (kind_reg != W_INIT)
                begin
                    result_next.now_row    = row_reg;
                    result_next.now_col    = col_reg;
                    result_next.did_scroll = (kind_reg == W_SCROLL);
                    done_next              = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_WALK;
            kind_reg    <= W_INIT;
            cnt_reg     <= '0;
            wr_pend_reg <= 1'b0;
            row_reg     <= '0;
            col_reg     <= '0;
            done_reg    <= 1'b0;
            fg_reg      <= tmtw_pkg::RESET_FG;
            bg_reg      <= tmtw_pkg::RESET_BG;
        end
        else
        begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            cnt_reg     <= cnt_next;
            wr_pend_reg <= wr_pend_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            done_reg    <= done_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    tmtw_pkg::CFG_FG: fg_reg <= cfg_data;
                    tmtw_pkg::CFG_BG: bg_reg <= cfg_data;
                    default:          fg_reg <= fg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_blank_reg <= wr_blank_next;
        wr_addr_reg  <= wr_addr_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: src/tmtw_checker.sv
// Port-level checks for the terminal writer, bound to the top level.
// Depends on tmtw_pkg and text_mode_terminal_writer_core.
`default_nettype none

module tmtw_checker #(
    parameter int COLUMNS = tmtw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tmtw_pkg::ROWS_DEF
) (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              done,
    input wire tmtw_pkg::result_t result
);

    // a result transfer is only shown once the command has finished
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // every accepted command answers next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted command neither answered nor busy");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((int'(result.now_row) < ROWS) && (int'(result.now_col) < COLUMNS)))
        else $error("cursor out of screen");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.did_scroll) |->
            ((result.now_col == '0) && (int'(result.now_row) == ROWS - 1)))
        else $error("cursor not at last row start after scroll");

endmodule

bind text_mode_terminal_writer_core tmtw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tmtw_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
